[sv/tle_pkg.sv]
// ============================================================================
// tle_pkg: shared types and constants of the telnet input line editor
// Item and result formats, parser phases, decoder actions, telnet codes and
// configuration register indexes.
// ============================================================================
package tle_pkg;

    // ------------------------------------------------------------------
    // Channel payloads
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [8:0] read_index;
    } in_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [8:0] count;
        logic       last;
    } out_t;

    // Item kinds
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result kinds
    localparam logic [1:0] OK_BYTE  = 2'd0;
    localparam logic [1:0] OK_ERASE = 2'd1;
    localparam logic [1:0] OK_LINE  = 2'd2;
    localparam logic [1:0] OK_READ  = 2'd3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_TEXT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_LENGTH = 1'd1;

    localparam logic [63:0] PROMPT_TEXT_RST   = 64'h0000_0020_3E4B_544D;
    localparam logic [3:0]  PROMPT_LENGTH_RST = 4'd5;

    // ------------------------------------------------------------------
    // Telnet command bytes and options
    // ------------------------------------------------------------------
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_NAWS = 8'd31;

    // Pending verb, in wire order starting at WILL
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    // ------------------------------------------------------------------
    // Character codes
    // ------------------------------------------------------------------
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_NAK      = 8'h15;
    localparam logic [7:0] CH_ETB      = 8'h17;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PARAM_HI = 8'h3F;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    // ------------------------------------------------------------------
    // Parser phase and decoder action
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        PH_TEXT    = 3'd0,
        PH_IAC     = 3'd1,
        PH_VERB    = 3'd2,
        PH_SUB     = 3'd3,
        PH_SUB_IAC = 3'd4,
        PH_ESC     = 3'd5,
        PH_CSI     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_STORE,
        ACT_LINE,
        ACT_BS,
        ACT_KILL,
        ACT_WORD,
        ACT_INTR,
        ACT_REPLY
    } act_t;

    // Parser context handed to the decoder
    typedef struct packed {
        phase_t     phase;
        logic [1:0] verb;
        logic       drop;
        logic       empty;
        logic       full;
    } ctx_t;

    // Decoder verdict for one received byte
    typedef struct packed {
        phase_t     phase;
        logic [1:0] verb;
        logic       drop;
        act_t       act;
        logic [7:0] reply;
    } dec_t;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEQ,
        ST_SCAN,
        ST_ERASE
    } st_t;

    function automatic out_t make_result(
        input logic [1:0] kind,
        input logic [7:0] data,
        input logic [8:0] cnt,
        input logic       fin
    );
        out_t r;
        r.out_kind = kind;
        r.out_byte = data;
        r.count    = cnt;
        r.last     = fin;
        return r;
    endfunction

endpackage

[sv/tle_decode.sv]
// ============================================================================
// tle_decode: telnet receive byte decoder
// Classifies one received byte against the parser phase and tells the
// sequencer the next phase and which line edit or reply to perform.
// ============================================================================
module tle_decode (
    input  tle_pkg::ctx_t ctx,
    input  logic [7:0]    rx_byte,
    output tle_pkg::dec_t dec
);

    // Ordinary text handling, shared by the text, ESC and CSI phases
    function automatic tle_pkg::dec_t text_byte(
        input logic [7:0]    c,
        input logic          empty,
        input logic          full,
        input tle_pkg::dec_t base
    );
        tle_pkg::dec_t r;
        r       = base;
        r.phase = tle_pkg::PH_TEXT;
        r.act   = tle_pkg::ACT_NONE;
        if (c == tle_pkg::TN_IAC)
        begin
            r.phase = tle_pkg::PH_IAC;
        end
        else if (c inside {tle_pkg::CH_CR, tle_pkg::CH_LF})
        begin
            r.act = tle_pkg::ACT_LINE;
            if (c == tle_pkg::CH_CR)
            begin
                r.drop = 1'b1;
            end
        end
        else if (c == tle_pkg::CH_ESC)
        begin
            r.phase = tle_pkg::PH_ESC;
        end
        else if (c inside {tle_pkg::CH_BS, tle_pkg::CH_DEL})
        begin
            r.act = empty ? tle_pkg::ACT_NONE : tle_pkg::ACT_BS;
        end
        else if (c == tle_pkg::CH_ETX)
        begin
            r.act = tle_pkg::ACT_INTR;
        end
        else if (c == tle_pkg::CH_NAK)
        begin
            r.act = empty ? tle_pkg::ACT_NONE : tle_pkg::ACT_KILL;
        end
        else if (c == tle_pkg::CH_ETB)
        begin
            r.act = empty ? tle_pkg::ACT_NONE : tle_pkg::ACT_WORD;
        end
        else if (c < tle_pkg::CH_SPACE)
        begin
            r.act = tle_pkg::ACT_NONE;
        end
        else
        begin
            r.act = full ? tle_pkg::ACT_NONE : tle_pkg::ACT_ECHO;
        end
        return r;
    endfunction

    logic [7:0] verb_diff;

    assign verb_diff = rx_byte - tle_pkg::TN_WILL;

    always_comb
    begin
        dec.phase = tle_pkg::PH_TEXT;
        dec.verb  = ctx.verb;
        dec.drop  = ctx.drop;
        dec.act   = tle_pkg::ACT_NONE;
        dec.reply = tle_pkg::TN_WONT;

        case (ctx.phase)
            tle_pkg::PH_IAC:
            begin
                if (rx_byte == tle_pkg::TN_IAC)
                begin
                    dec.act = ctx.full ? tle_pkg::ACT_NONE : tle_pkg::ACT_STORE;
                end
                else if (rx_byte == tle_pkg::TN_SB)
                begin
                    dec.phase = tle_pkg::PH_SUB;
                end
                else if (rx_byte >= tle_pkg::TN_WILL)
                begin
                    dec.phase = tle_pkg::PH_VERB;
                    dec.verb  = verb_diff[1:0];
                end
            end

            tle_pkg::PH_VERB:
            begin
                dec.act = tle_pkg::ACT_REPLY;
                case (ctx.verb)
                    tle_pkg::VERB_WILL:
                        dec.reply = (rx_byte == tle_pkg::OPT_SGA || rx_byte == tle_pkg::OPT_NAWS)
                                    ? tle_pkg::TN_DO : tle_pkg::TN_DONT;
                    tle_pkg::VERB_WONT:
                        dec.reply = tle_pkg::TN_DONT;
                    tle_pkg::VERB_DO:
                        dec.reply = (rx_byte == tle_pkg::OPT_ECHO || rx_byte == tle_pkg::OPT_SGA)
                                    ? tle_pkg::TN_WILL : tle_pkg::TN_WONT;
                    default:
                        dec.reply = tle_pkg::TN_WONT;
                endcase
            end

            tle_pkg::PH_SUB:
            begin
                dec.phase = (rx_byte == tle_pkg::TN_IAC) ? tle_pkg::PH_SUB_IAC
                                                         : tle_pkg::PH_SUB;
            end

            tle_pkg::PH_SUB_IAC:
            begin
                if (rx_byte == tle_pkg::TN_SE)
                begin
                    dec.phase = tle_pkg::PH_TEXT;
                end
                else if (rx_byte == tle_pkg::TN_IAC)
                begin
                    dec.phase = tle_pkg::PH_SUB_IAC;
                end
                else
                begin
                    dec.phase = tle_pkg::PH_SUB;
                end
            end

            tle_pkg::PH_ESC:
            begin
                if (rx_byte == tle_pkg::CH_LBRACKET)
                begin
                    dec.phase = tle_pkg::PH_CSI;
                end
                else
                begin
                    dec = text_byte(rx_byte, ctx.empty, ctx.full, dec);
                end
            end

            tle_pkg::PH_CSI:
            begin
                if (rx_byte inside {[tle_pkg::CH_FINAL_LO:tle_pkg::CH_FINAL_HI]})
                begin
                    dec.phase = tle_pkg::PH_TEXT;
                end
                else if (rx_byte inside {[tle_pkg::CH_SPACE:tle_pkg::CH_PARAM_HI]})
                begin
                    dec.phase = tle_pkg::PH_CSI;
                end
                else
                begin
                    dec = text_byte(rx_byte, ctx.empty, ctx.full, dec);
                end
            end

            default:
            begin
                // Text phase: the byte after CR drops a NUL or LF
                dec.drop = 1'b0;
                if (!(ctx.drop && (rx_byte inside {tle_pkg::CH_NUL, tle_pkg::CH_LF})))
                begin
                    dec = text_byte(rx_byte, ctx.empty, ctx.full, dec);
                end
            end
        endcase
    end

endmodule

[sv/telnet_input_line_editor.sv]
// ============================================================================
// telnet_input_line_editor: telnet receive path with line editing
// Strips telnet commands and ANSI CSI sequences, answers option
// negotiation, edits a line held in an on-chip store and echoes text.
// ============================================================================
//
// One item is worked on at a time. A received byte that gives at most one
// result (echo, erase, line complete) or none, Ctrl+W apart, leaves the
// block idle, so plain typing runs at one byte per clock while the result
// side keeps up. A read item launches the synchronous line store read when
// taken and then presents the byte. An option reply gives 3 result bytes
// after the transfer; Ctrl+C gives ^C, CR, LF and the prompt, whose length
// is capped at 8. Ctrl+W walks back through the line store one byte per
// cycle through its single read port, then gives one erase result. A stall
// on the result side holds the read, reply and erase steps. The line store
// has no reset and no clearing pass: reading a slot that was never written
// returns whatever the RAM holds. Configuration writes are taken on any
// cycle but should only be made while the block is idle.
//
module telnet_input_line_editor #(
    parameter int LINE_DEPTH = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              item_valid,
    output logic                              item_stall,
    input  tle_pkg::in_t                      item,

    output logic                              result_valid,
    input  logic                              result_stall,
    output tle_pkg::out_t                     result,

    input  logic                              cfg_write,
    input  logic [tle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tle_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int              AW       = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0]   LEN_FULL = AW'(LINE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tle_pkg::st_t    state_reg, state_next;
    tle_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      verb_reg, verb_next;
    logic            drop_reg, drop_next;
    logic [AW-1:0]   len_reg, len_next;

    // Multi-byte reply sequencer
    logic            seq_intr_reg, seq_intr_next;
    logic [3:0]      seq_idx_reg, seq_idx_next;
    logic [3:0]      seq_total_reg, seq_total_next;
    logic [7:0]      seq_resp_reg, seq_resp_next;
    logic [7:0]      seq_opt_reg, seq_opt_next;

    // Ctrl+W back scan
    logic            scan_skip_reg, scan_skip_next;
    logic [AW-1:0]   scan_cnt_reg, scan_cnt_next;

    // Read item: out-of-range flag
    logic            rd_zero_reg, rd_zero_next;

    // Result register
    logic            out_valid_reg, out_valid_next;
    tle_pkg::out_t   out_reg, out_next;

    // Configuration
    logic [63:0]     prompt_text_reg, prompt_text_next;
    logic [3:0]      prompt_length_reg, prompt_length_next;

    // Line store
    logic [7:0]      line_mem [LINE_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic accept;

    // The result register can take a new result when empty or draining now
    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = !((state_reg == tle_pkg::ST_IDLE) && out_free);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Byte decoder
    // ------------------------------------------------------------------
    tle_pkg::ctx_t ctx;
    tle_pkg::dec_t dec;

    always_comb
    begin
        ctx.phase = phase_reg;
        ctx.verb  = verb_reg;
        ctx.drop  = drop_reg;
        ctx.empty = (len_reg == '0);
        ctx.full  = (len_reg == LEN_FULL);
    end

    tle_decode u_decode (
        .ctx     (ctx),
        .rx_byte (item.rx_byte),
        .dec     (dec)
    );

    // ------------------------------------------------------------------
    // Width adaptation between the line store and the fixed 9-bit fields
    // ------------------------------------------------------------------
    logic [AW+8:0]  ridx_ext;
    logic [AW-1:0]  read_addr;
    logic           read_in_range;
    logic [AW+8:0]  len_ext;
    logic [8:0]     len_cnt;
    logic [AW+8:0]  scan_ext;
    logic [8:0]     scan_cnt9;

    assign ridx_ext      = {{AW{1'b0}}, item.read_index};
    assign read_addr     = ridx_ext[AW-1:0];
    assign read_in_range = (32'(item.read_index) < 32'(LINE_DEPTH));
    assign len_ext       = {9'd0, len_reg};
    assign len_cnt       = len_ext[8:0];
    assign scan_ext      = {9'd0, scan_cnt_reg};
    assign scan_cnt9     = scan_ext[8:0];

    // ------------------------------------------------------------------
    // Sequencer byte select: option reply or Ctrl+C echo with prompt
    // ------------------------------------------------------------------
    logic [3:0] prompt_n;
    logic [3:0] prompt_pos;
    logic [7:0] seq_byte;
    logic       seq_last;

    assign prompt_n   = prompt_length_reg[3] ? 4'd8 : prompt_length_reg;
    assign prompt_pos = seq_idx_reg - 4'd4;
    assign seq_last   = ((seq_idx_reg + 4'd1) == seq_total_reg);

    always_comb
    begin
        seq_byte = tle_pkg::CH_NUL;
        if (seq_intr_reg)
        begin
            case (seq_idx_reg)
                4'd0:    seq_byte = tle_pkg::CH_CARET;
                4'd1:    seq_byte = tle_pkg::CH_C;
                4'd2:    seq_byte = tle_pkg::CH_CR;
                4'd3:    seq_byte = tle_pkg::CH_LF;
                default: seq_byte = prompt_text_reg[{prompt_pos[2:0], 3'b000} +: 8];
            endcase
        end
        else
        begin
            case (seq_idx_reg)
                4'd0:    seq_byte = tle_pkg::TN_IAC;
                4'd1:    seq_byte = seq_resp_reg;
                default: seq_byte = seq_opt_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ctrl+W scan step: rd_data_reg holds the byte just below the cursor
    // ------------------------------------------------------------------
    logic          scan_take;
    logic [AW-1:0] scan_len;
    logic          scan_done;

    // Skip trailing spaces first, then take the word until a space
    assign scan_take = scan_skip_reg || (rd_data_reg != tle_pkg::CH_SPACE);
    assign scan_len  = len_reg - 1'b1;
    assign scan_done = !scan_take || (scan_len == '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == tle_pkg::KIND_READ)
                    begin
                        state_next = tle_pkg::ST_READ;
                    end
                    else
                    begin
                        case (dec.act)
                            tle_pkg::ACT_WORD:  state_next = tle_pkg::ST_SCAN;
                            tle_pkg::ACT_INTR,
                            tle_pkg::ACT_REPLY: state_next = tle_pkg::ST_SEQ;
                            default:            state_next = tle_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            tle_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_SEQ:
            begin
                if (out_free && seq_last)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = tle_pkg::ST_ERASE;
                end
            end
            tle_pkg::ST_ERASE:
            begin
                if (out_free)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, line store access and results
    // ------------------------------------------------------------------
    logic          emit;
    tle_pkg::out_t emit_item;

    always_comb
    begin
        phase_next     = phase_reg;
        verb_next      = verb_reg;
        drop_next      = drop_reg;
        len_next       = len_reg;
        seq_intr_next  = seq_intr_reg;
        seq_idx_next   = seq_idx_reg;
        seq_total_next = seq_total_reg;
        seq_resp_next  = seq_resp_reg;
        seq_opt_next   = seq_opt_reg;
        scan_skip_next = scan_skip_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_zero_next   = rd_zero_reg;
        emit           = 1'b0;
        emit_item      = '0;
        mem_we         = 1'b0;
        mem_waddr      = len_reg;
        mem_wdata      = item.rx_byte;
        mem_re         = 1'b0;
        mem_raddr      = read_addr;

        case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                if (accept && item.kind == tle_pkg::KIND_READ)
                begin
                    // Launch the store read; the byte shows up next cycle
                    mem_re       = 1'b1;
                    mem_raddr    = read_addr;
                    rd_zero_next = !read_in_range;
                end
                else if (accept)
                begin
                    phase_next = dec.phase;
                    verb_next  = dec.verb;
                    drop_next  = dec.drop;
                    case (dec.act)
                        tle_pkg::ACT_ECHO:
                        begin
                            mem_we    = 1'b1;
                            len_next  = len_reg + 1'b1;
                            emit      = 1'b1;
                            emit_item = tle_pkg::make_result(tle_pkg::OK_BYTE,
                                                             item.rx_byte, 9'd0, 1'b1);
                        end
                        tle_pkg::ACT_STORE:
                        begin
                            // Literal 0xFF: store without echo
                            mem_we   = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        tle_pkg::ACT_LINE:
                        begin
                            len_next  = '0;
                            emit      = 1'b1;
                            emit_item = tle_pkg::make_result(tle_pkg::OK_LINE,
                                                             8'd0, len_cnt, 1'b1);
                        end
                        tle_pkg::ACT_BS:
                        begin
                            len_next  = len_reg - 1'b1;
                            emit      = 1'b1;
                            emit_item = tle_pkg::make_result(tle_pkg::OK_ERASE,
                                                             8'd0, 9'd1, 1'b1);
                        end
                        tle_pkg::ACT_KILL:
                        begin
                            len_next  = '0;
                            emit      = 1'b1;
                            emit_item = tle_pkg::make_result(tle_pkg::OK_ERASE,
                                                             8'd0, len_cnt, 1'b1);
                        end
                        tle_pkg::ACT_WORD:
                        begin
                            // Fetch the byte under the cursor and start the scan
                            mem_re         = 1'b1;
                            mem_raddr      = len_reg - 1'b1;
                            scan_skip_next = 1'b1;
                            scan_cnt_next  = '0;
                        end
                        tle_pkg::ACT_INTR:
                        begin
                            len_next       = '0;
                            seq_intr_next  = 1'b1;
                            seq_idx_next   = 4'd0;
                            seq_total_next = 4'd4 + prompt_n;
                        end
                        tle_pkg::ACT_REPLY:
                        begin
                            seq_intr_next  = 1'b0;
                            seq_idx_next   = 4'd0;
                            seq_total_next = 4'd3;
                            seq_resp_next  = dec.reply;
                            seq_opt_next   = item.rx_byte;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end

            tle_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_item = tle_pkg::make_result(tle_pkg::OK_READ,
                                                     rd_zero_reg ? 8'd0 : rd_data_reg,
                                                     9'd0, 1'b1);
                end
            end

            tle_pkg::ST_SEQ:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    emit_item    = tle_pkg::make_result(tle_pkg::OK_BYTE, seq_byte,
                                                        9'd0, seq_last);
                    seq_idx_next = seq_idx_reg + 4'd1;
                end
            end

            tle_pkg::ST_SCAN:
            begin
                if (scan_take)
                begin
                    len_next      = scan_len;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    if (rd_data_reg != tle_pkg::CH_SPACE)
                    begin
                        scan_skip_next = 1'b0;
                    end
                end
                if (!scan_done)
                begin
                    // Fetch the next byte down
                    mem_re    = 1'b1;
                    mem_raddr = scan_len - 1'b1;
                end
            end

            tle_pkg::ST_ERASE:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_item = tle_pkg::make_result(tle_pkg::OK_ERASE, 8'd0,
                                                     scan_cnt9, 1'b1);
                end
            end

            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Hold a stalled result; drop it once its transfer completes
        out_valid_next = emit || (out_valid_reg && result_stall);
        out_next       = emit ? emit_item : out_reg;
    end

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_comb
    begin
        prompt_text_next   = prompt_text_reg;
        prompt_length_next = prompt_length_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tle_pkg::CFG_PROMPT_TEXT:   prompt_text_next   = cfg_data;
                tle_pkg::CFG_PROMPT_LENGTH: prompt_length_next = cfg_data[3:0];
                default:                    prompt_text_next   = prompt_text_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tle_pkg::ST_IDLE;
            phase_reg         <= tle_pkg::PH_TEXT;
            verb_reg          <= tle_pkg::VERB_WILL;
            drop_reg          <= 1'b0;
            len_reg           <= '0;
            out_valid_reg     <= 1'b0;
            prompt_text_reg   <= tle_pkg::PROMPT_TEXT_RST;
            prompt_length_reg <= tle_pkg::PROMPT_LENGTH_RST;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            verb_reg          <= verb_next;
            drop_reg          <= drop_next;
            len_reg           <= len_next;
            out_valid_reg     <= out_valid_next;
            prompt_text_reg   <= prompt_text_next;
            prompt_length_reg <= prompt_length_next;
        end
    end

    // Payload and work registers: no reset needed
    always_ff @(posedge clk)
    begin
        seq_intr_reg  <= seq_intr_next;
        seq_idx_reg   <= seq_idx_next;
        seq_total_reg <= seq_total_next;
        seq_resp_reg  <= seq_resp_next;
        seq_opt_reg   <= seq_opt_next;
        scan_skip_reg <= scan_skip_next;
        scan_cnt_reg  <= scan_cnt_next;
        rd_zero_reg   <= rd_zero_next;
        out_reg       <= out_next;
    end

    // ------------------------------------------------------------------
    // Line store: one write port, one registered read port. Only one item
    // is in flight, so a write and a read of the same slot never overlap.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[mem_raddr];
        end
    end

endmodule

[sv/tle_checker.sv]
// ============================================================================
// tle_checker: port-level checks for the telnet input line editor
// Watches the result channel for field combinations the block never makes
// and for a result that changes while stalled.
// ============================================================================
module tle_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_stall,
    input logic          result_valid,
    input logic          result_stall,
    input tle_pkg::out_t result
);

    // A stalled result holds until its transfer
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result)
    ) else $error("result changed while stalled");

    // A read item gives exactly one result, so it always closes the item
    a_read_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == tle_pkg::OK_READ |-> result.last
    ) else $error("read result without last");

    // Erase and line results carry no byte
    a_count_no_byte: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && (result.out_kind == tle_pkg::OK_ERASE ||
                         result.out_kind == tle_pkg::OK_LINE)
        |-> result.out_byte == 8'd0
    ) else $error("count result with nonzero byte");

    // Byte and read results carry no count
    a_byte_no_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && (result.out_kind == tle_pkg::OK_BYTE ||
                         result.out_kind == tle_pkg::OK_READ)
        |-> result.count == 9'd0
    ) else $error("byte result with nonzero count");

    // No new item is taken while a result that is not the last of its item is
    // pending and the block is busy with more results of the previous one
    a_no_accept_mid_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall || !item_valid
    ) else $error("item taken before previous item finished");

endmodule

bind telnet_input_line_editor tle_checker u_tle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/sv/tb_telnet_input_line_editor.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_telnet_input_line_editor: self-checking bench for the telnet line editor
// Runs a table of directed bytes, then random telnet traffic built from
// typed words, edits, option negotiation, subnegotiations, CSI sequences and
// line-store reads. A behavioral copy of the editor predicts every result,
// and each transfer on the result side is checked field by field.
// ============================================================================
module tb_telnet_input_line_editor;
    import tle_pkg::*;

    localparam int DEPTH       = 512;   // line store depth of the instance
    localparam int LONG_HOLD   = 120;   // cycles of the long result-side hold-off
    localparam int TAIL_CYCLES = 20;    // quiet cycles after the last result
    localparam int DIR_ROWS    = 27;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_t                   item;
    logic                  result_valid;
    logic                  result_stall;
    out_t                  result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    telnet_input_line_editor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Directed table. Rows with typed set carry the single result that
    // the byte must give; the rest are left to the editor copy below.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [8:0] index;
        logic       typed;
        logic [1:0] rkind;
        logic [7:0] rbyte;
        logic [8:0] rcount;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{KIND_RX,   CH_BS,       9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // empty line
        '{KIND_RX,   8'h61,       9'd511, 1'b1, OK_BYTE,  8'h61,    9'd0},
        '{KIND_RX,   CH_SPACE,    9'd256, 1'b1, OK_BYTE,  CH_SPACE, 9'd0},
        '{KIND_RX,   8'hFE,       9'd255, 1'b1, OK_BYTE,  8'hFE,    9'd0},
        '{KIND_RX,   CH_DEL,      9'd0,   1'b1, OK_ERASE, CH_NUL,   9'd1},
        '{KIND_RX,   TN_IAC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // literal 0xFF,
        '{KIND_RX,   TN_IAC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // stored silently
        '{KIND_READ, 8'hFF,       9'd2,   1'b1, OK_READ,  TN_IAC,   9'd0},
        '{KIND_READ, CH_NUL,      9'd0,   1'b1, OK_READ,  8'h61,    9'd0},
        '{KIND_RX,   CH_ETB,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   CH_NAK,      9'd0,   1'b1, OK_ERASE, CH_NUL,   9'd2},
        '{KIND_RX,   TN_IAC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // DO ECHO
        '{KIND_RX,   TN_DO,       9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   OPT_ECHO,    9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   TN_IAC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // empty SB .. SE
        '{KIND_RX,   TN_SB,       9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   TN_IAC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   TN_SE,       9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   CH_ESC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // CSI with a
        '{KIND_RX,   CH_LBRACKET, 9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // parameter byte
        '{KIND_RX,   CH_PARAM_HI, 9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   CH_FINAL_HI, 9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0},
        '{KIND_RX,   CH_ESC,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // lone ESC
        '{KIND_RX,   8'h78,       9'd0,   1'b1, OK_BYTE,  8'h78,    9'd0},
        '{KIND_RX,   CH_CR,       9'd0,   1'b1, OK_LINE,  CH_NUL,   9'd1},
        '{KIND_RX,   CH_NUL,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}, // dropped after CR
        '{KIND_RX,   CH_ETX,      9'd0,   1'b0, OK_BYTE,  CH_NUL,   9'd0}
    };

    // ------------------------------------------------------------------
    // Editor copy: parser phase, line store and prompt registers
    // ------------------------------------------------------------------
    phase_t      ed_phase = PH_TEXT;
    logic [1:0]  ed_verb  = VERB_WILL;
    bit          ed_drop  = 1'b0;
    int unsigned ed_len   = 0;
    int unsigned ed_peak  = 0;
    logic [7:0]  ed_store [DEPTH];
    bit          ed_written [DEPTH];
    logic [63:0] ed_prompt = PROMPT_TEXT_RST;
    logic [3:0]  ed_plen   = PROMPT_LENGTH_RST;
    out_t        edit_out [$];          // results of the byte being worked on

    // Bookkeeping between sender, monitor and checker
    typedef struct {
        bit   typed;
        out_t want;
    } typed_t;

    typed_t typed_q [$];                // one entry per offered item, in order
    out_t   awaited [$];                // results still to come from the block

    int errors       = 0;
    int items_in     = 0;
    int useful_items = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int holds_done   = 0;
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    function automatic void put_result(logic [1:0] k, logic [7:0] b, logic [8:0] n);
        out_t r;
        r.out_kind = k;
        r.out_byte = b;
        r.count    = n;
        r.last     = 1'b0;
        edit_out.push_back(r);
    endfunction

    function automatic void store_byte(logic [7:0] c);
        ed_store[ed_len]   = c;
        ed_written[ed_len] = 1'b1;
        ed_len++;
        if (ed_len > ed_peak)
            ed_peak = ed_len;
    endfunction

    // Text-phase handling of one byte: editing keys, line end, echo.
    function automatic void take_text(logic [7:0] c);
        int unsigned n;
        n = 0;
        if (c == TN_IAC) begin
            ed_phase = PH_IAC;
        end else if (c == CH_CR || c == CH_LF) begin
            put_result(OK_LINE, CH_NUL, 9'(ed_len));
            ed_len = 0;
            if (c == CH_CR)
                ed_drop = 1'b1;
        end else if (c == CH_ESC) begin
            ed_phase = PH_ESC;
        end else if (c == CH_BS || c == CH_DEL) begin
            if (ed_len > 0) begin
                ed_len--;
                put_result(OK_ERASE, CH_NUL, 9'd1);
            end
        end else if (c == CH_ETX) begin
            // ^C, new line, then the prompt, capped at eight characters
            ed_len = 0;
            put_result(OK_BYTE, CH_CARET, 9'd0);
            put_result(OK_BYTE, CH_C, 9'd0);
            put_result(OK_BYTE, CH_CR, 9'd0);
            put_result(OK_BYTE, CH_LF, 9'd0);
            n = (ed_plen > 4'd8) ? 8 : ed_plen;
            for (int k = 0; k < n; k++)
                put_result(OK_BYTE, ed_prompt[8*k +: 8], 9'd0);
        end else if (c == CH_NAK) begin
            if (ed_len > 0)
                put_result(OK_ERASE, CH_NUL, 9'(ed_len));
            ed_len = 0;
        end else if (c == CH_ETB) begin
            // trailing spaces first, then the word before them
            while (ed_len > 0 && ed_store[ed_len-1] == CH_SPACE) begin
                ed_len--;
                n++;
            end
            while (ed_len > 0 && ed_store[ed_len-1] != CH_SPACE) begin
                ed_len--;
                n++;
            end
            if (n > 0)
                put_result(OK_ERASE, CH_NUL, 9'(n));
        end else if (c < CH_SPACE) begin
            // other control bytes and TAB: ignored
        end else if (ed_len < DEPTH - 1) begin
            store_byte(c);
            put_result(OK_BYTE, c, 9'd0);
        end
    endfunction

    function automatic void answer_option(logic [7:0] opt);
        logic [7:0] verb;
        case (ed_verb)
            VERB_WILL: verb = (opt == OPT_SGA || opt == OPT_NAWS) ? TN_DO : TN_DONT;
            VERB_WONT: verb = TN_DONT;
            VERB_DO:   verb = (opt == OPT_ECHO || opt == OPT_SGA) ? TN_WILL : TN_WONT;
            default:   verb = TN_WONT;
        endcase
        put_result(OK_BYTE, TN_IAC, 9'd0);
        put_result(OK_BYTE, verb, 9'd0);
        put_result(OK_BYTE, opt, 9'd0);
    endfunction

    // Work out the results of one item into edit_out. Returns whether the
    // item did anything at all (a result or a change of parser or line).
    function automatic bit line_editor_step(in_t it);
        logic [7:0]  c;
        phase_t      was_phase;
        int unsigned was_len;
        bit          was_drop;
        logic [1:0]  was_verb;
        c         = it.rx_byte;
        was_phase = ed_phase;
        was_len   = ed_len;
        was_drop  = ed_drop;
        was_verb  = ed_verb;
        edit_out.delete();
        if (it.kind == KIND_READ) begin
            put_result(OK_READ, ed_store[it.read_index], 9'd0);
        end else begin
            case (ed_phase)
                PH_IAC: begin
                    ed_phase = PH_TEXT;
                    if (c == TN_IAC) begin
                        if (ed_len < DEPTH - 1)
                            store_byte(TN_IAC);
                    end else if (c == TN_SB) begin
                        ed_phase = PH_SUB;
                    end else if (c >= TN_WILL) begin
                        ed_verb  = 2'(c - TN_WILL);
                        ed_phase = PH_VERB;
                    end
                end
                PH_VERB: begin
                    ed_phase = PH_TEXT;
                    answer_option(c);
                end
                PH_SUB: begin
                    if (c == TN_IAC)
                        ed_phase = PH_SUB_IAC;
                end
                PH_SUB_IAC: begin
                    if (c == TN_SE)
                        ed_phase = PH_TEXT;
                    else if (c != TN_IAC)
                        ed_phase = PH_SUB;
                end
                PH_ESC: begin
                    if (c == CH_LBRACKET) begin
                        ed_phase = PH_CSI;
                    end else begin
                        ed_phase = PH_TEXT;
                        take_text(c);
                    end
                end
                PH_CSI: begin
                    if (c >= CH_FINAL_LO && c <= CH_FINAL_HI) begin
                        ed_phase = PH_TEXT;
                    end else if (c < CH_SPACE || c > CH_FINAL_HI) begin
                        ed_phase = PH_TEXT;
                        take_text(c);
                    end
                end
                default: begin
                    ed_phase = PH_TEXT;
                    if (ed_drop && (c == CH_NUL || c == CH_LF)) begin
                        ed_drop = 1'b0;
                    end else begin
                        ed_drop = 1'b0;
                        take_text(c);
                    end
                end
            endcase
        end
        if (edit_out.size() > 0)
            edit_out[edit_out.size()-1].last = 1'b1;
        return edit_out.size() > 0 || ed_phase != was_phase || ed_len != was_len ||
               ed_drop != was_drop || ed_verb != was_verb;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 100)
            $display("%0t mismatch, %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic accept_item(in_t it);
        typed_t o;
        items_in++;
        if (line_editor_step(it))
            useful_items++;
        if (typed_q.size() != 0) begin
            o = typed_q.pop_front();
            // a typed row overrides the computed result
            if (o.typed) begin
                edit_out.delete();
                edit_out.push_back(o.want);
            end
        end
        foreach (edit_out[i])
            awaited.push_back(edit_out[i]);
    endtask

    task automatic check_result(out_t got);
        out_t want;
        results_seen++;
        if (awaited.size() == 0) begin
            note_mismatch("result with nothing awaited", got, '0);
            return;
        end
        want = awaited.pop_front();
        if (got.out_kind !== want.out_kind)
            note_mismatch("out_kind", got.out_kind, want.out_kind);
        if (got.out_byte !== want.out_byte)
            note_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.count !== want.count)
            note_mismatch("count", got.count, want.count);
        if (got.last !== want.last)
            note_mismatch("last", got.last, want.last);
    endtask

    // Sample every transfer at the rising edge. The item is handled before
    // the result so a same-edge result would still find its expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_write) begin
                cfg_writes++;
                if (cfg_index == CFG_PROMPT_TEXT)
                    ed_prompt = cfg_data;
                else if (cfg_index == CFG_PROMPT_LENGTH)
                    ed_plen = cfg_data[3:0];
            end
            if (item_valid && !item_stall)
                accept_item(item);
            if (result_valid && !result_stall)
                check_result(result);
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, open runs, and on request one long
    // hold-off so the block backs up into the item side.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int open_left;
        stall_left   = 0;
        open_left    = 0;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                holds_done++;
            end
            if (stall_left > 0) begin
                result_stall = 1'b1;
                stall_left--;
            end else if (open_left > 0) begin
                result_stall = 1'b0;
                open_left--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                result_stall = 1'b1;
                stall_left   = $urandom_range(0, 12);
            end else begin
                result_stall = 1'b0;
                if (!idle_on)
                    open_left = 0;
                else if ($urandom_range(0, 9) == 0)
                    open_left = 60;
                else
                    open_left = $urandom_range(0, 15);
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------
    function automatic in_t rx(logic [7:0] b);
        in_t it;
        it.kind       = KIND_RX;
        it.rx_byte    = b;
        it.read_index = 9'($urandom_range(0, DEPTH - 1));
        return it;
    endfunction

    function automatic in_t rd(logic [8:0] idx);
        in_t it;
        it.kind       = KIND_READ;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.read_index = idx;
        return it;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_SPACE + 1, CH_FINAL_HI));
    endfunction

    // Offer one item and hold it until the transfer; maybe idle first.
    task automatic offer(in_t it, bit typed = 1'b0, out_t want = '0);
        typed_t o;
        int     gap;
        o.typed = typed;
        o.want  = want;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_valid = 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        typed_q.push_back(o);
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every awaited result is in, then let the
    // block finish any silent item before the next register write.
    task automatic settle(int tail);
        @(negedge clk);
        item_valid = 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // One random well-formed sequence, or a little noise.
    task automatic send_sequence();
        in_t        seq [$];
        int         pick;
        int         n;
        logic [7:0] b;
        logic [8:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // a word, maybe after spaces, now and then with high bytes
            n = $urandom_range(0, 2);
            repeat (n) seq.push_back(rx(CH_SPACE));
            n = $urandom_range(1, 8);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    seq.push_back(rx(8'($urandom_range(CH_DEL + 1, TN_IAC - 1))));
                else
                    seq.push_back(rx(printable()));
            end
        end else if (pick < 42) begin
            case ($urandom_range(0, 4))
                0:       b = CH_BS;
                1:       b = CH_DEL;
                2:       b = CH_NAK;
                default: b = CH_ETB;
            endcase
            seq.push_back(rx(b));
        end else if (pick < 52) begin
            if ($urandom_range(0, 3) == 0) begin
                seq.push_back(rx(CH_LF));
            end else begin
                seq.push_back(rx(CH_CR));
                case ($urandom_range(0, 3))
                    0:       seq.push_back(rx(CH_NUL));
                    1:       seq.push_back(rx(CH_LF));
                    2:       seq.push_back(rx(printable()));
                    default: ;
                endcase
            end
        end else if (pick < 62) begin
            // option negotiation
            seq.push_back(rx(TN_IAC));
            seq.push_back(rx(8'(TN_WILL + $urandom_range(0, 3))));
            case ($urandom_range(0, 4))
                0:       b = OPT_ECHO;
                1:       b = OPT_SGA;
                2:       b = OPT_NAWS;
                default: b = 8'($urandom_range(0, 255));
            endcase
            seq.push_back(rx(b));
        end else if (pick < 66) begin
            // two-byte command, ignored
            seq.push_back(rx(TN_IAC));
            if ($urandom_range(0, 1) == 0)
                seq.push_back(rx(8'($urandom_range(TN_SE, TN_SB - 1))));
            else
                seq.push_back(rx(8'($urandom_range(0, TN_SE - 1))));
        end else if (pick < 72) begin
            // subnegotiation; an escaped IAC inside must not end it
            seq.push_back(rx(TN_IAC));
            seq.push_back(rx(TN_SB));
            n = $urandom_range(0, 6);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                seq.push_back(rx(b));
                if (b == TN_IAC)
                    seq.push_back(rx(TN_IAC));
            end
            seq.push_back(rx(TN_IAC));
            seq.push_back(rx(TN_SE));
        end else if (pick < 80) begin
            // CSI: parameters, then a final byte or a byte that breaks it
            seq.push_back(rx(CH_ESC));
            seq.push_back(rx(CH_LBRACKET));
            n = $urandom_range(0, 3);
            repeat (n) seq.push_back(rx(8'($urandom_range(CH_SPACE, CH_PARAM_HI))));
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    seq.push_back(rx(8'($urandom_range(0, CH_SPACE - 1))));
                else
                    seq.push_back(rx(8'($urandom_range(CH_DEL, TN_IAC))));
            end else begin
                seq.push_back(rx(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI))));
            end
        end else if (pick < 84) begin
            seq.push_back(rx(CH_ESC));
            seq.push_back(rx(8'($urandom_range(0, 255))));
        end else if (pick < 87) begin
            seq.push_back(rx(TN_IAC));
            seq.push_back(rx(TN_IAC));
        end else if (pick < 90) begin
            seq.push_back(rx(CH_ETX));
        end else if (pick < 96) begin
            // read only positions that hold a written byte
            n = $urandom_range(1, 3);
            repeat (n) begin
                idx = 9'($urandom_range(0, DEPTH - 1));
                while (idx > 0 && !ed_written[idx])
                    idx--;
                if (ed_written[idx])
                    seq.push_back(rd(idx));
            end
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) seq.push_back(rx(8'($urandom_range(0, 255))));
        end
        foreach (seq[i])
            offer(seq[i]);
    endtask

    task automatic run_random(int target);
        int start;
        start = useful_items;
        while (useful_items - start < target)
            send_sequence();
    endtask

    // Fill the line to the brim and past it, with the long receiver
    // hold-off early on, then read back from the upper half.
    task automatic fill_line();
        // return the parser to text from any phase and empty the line
        offer(rx(TN_IAC));
        offer(rx(TN_SE));
        offer(rx(CH_NAK));
        for (int i = 0; i < DEPTH + 3; i++) begin
            if (i == 32)
                hold_request = 1'b1;
            offer(rx(($urandom_range(0, 6) == 0) ? CH_SPACE : printable()));
        end
        offer(rd(9'(DEPTH - 2)));
        repeat (6) offer(rd(9'($urandom_range(DEPTH / 2, DEPTH - 2))));
        offer(rx(CH_ETB));
        offer(rx(CH_ETB));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        out_t want;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_PROMPT_TEXT;
        cfg_data   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows under the reset prompt
        for (int r = 0; r < DIR_ROWS; r++) begin
            want = '{DIR_TABLE[r].rkind, DIR_TABLE[r].rbyte, DIR_TABLE[r].rcount, 1'b1};
            if (DIR_TABLE[r].kind == KIND_READ)
                offer(rd(DIR_TABLE[r].index), DIR_TABLE[r].typed, want);
            else
                offer('{KIND_RX, DIR_TABLE[r].data, DIR_TABLE[r].index},
                      DIR_TABLE[r].typed, want);
        end
        settle(TAIL_CYCLES);

        // full-length prompt of all-ones bytes
        write_reg(CFG_PROMPT_LENGTH, 64'd8);
        write_reg(CFG_PROMPT_TEXT, '1);
        run_random(90);
        settle(TAIL_CYCLES);

        // empty prompt; full line with back-pressure from the result side
        write_reg(CFG_PROMPT_TEXT, '0);
        write_reg(CFG_PROMPT_LENGTH, 64'd0);
        fill_line();
        run_random(40);
        settle(TAIL_CYCLES);

        // over-long prompt length (counts as eight), random text; the
        // sender pauses half way until the block has drained
        write_reg(CFG_PROMPT_LENGTH, {32'($urandom), 28'($urandom), 4'hF});
        write_reg(CFG_PROMPT_TEXT, {32'($urandom), 32'($urandom)});
        run_random(80);
        settle(0);
        run_random(80);
        settle(TAIL_CYCLES);

        // last stretch at full rate on both sides
        write_reg(CFG_PROMPT_LENGTH, 64'($urandom_range(1, 7)));
        idle_on = 1'b0;
        run_random(70);
        settle(TAIL_CYCLES);

        $display("covered %0d items (%0d with effect), %0d results, %0d register writes",
                 items_in, useful_items, results_seen, cfg_writes);
        $display("longest line %0d of %0d bytes, %0d long result hold-offs",
                 ed_peak, DEPTH - 1, holds_done);
        if (errors == 0)
            $display("tb_telnet_input_line_editor passed");
        else
            $display("tb_telnet_input_line_editor failed");
        $finish;
    end

    // Run limit: well above the slowest legal run (every item with its
    // largest result burst, each result behind a full stall, plus the
    // line-store scans and the long hold-off).
    initial begin
        #(20_000_000);
        $display("timeout with %0d results still awaited", awaited.size());
        $display("tb_telnet_input_line_editor failed");
        $finish;
    end

endmodule
